FILE: rtl/core/bfsam_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the control program of the breadth-first search block.
package bfsam_pkg;

  localparam int unsigned NODES  = 16;
  localparam int unsigned NODE_W = 4;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned PC_W   = 3;

  // Step addresses of the control program.
  localparam logic [PC_W-1:0] S_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] S_CHECK = 3'd1;
  localparam logic [PC_W-1:0] S_POP   = 3'd2;
  localparam logic [PC_W-1:0] S_SCAN  = 3'd3;
  localparam logic [PC_W-1:0] S_WAIT  = 3'd4;
  localparam logic [PC_W-1:0] S_EMIT  = 3'd5;
  localparam logic [PC_W-1:0] S_DONE  = 3'd6;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_IDLE,
    OP_INIT,
    OP_POP,
    OP_PUSH,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_BAD,
    C_MORE_CANDS,
    C_OUT_BUSY,
    C_QUEUE_NONEMPTY
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic no_start;
    logic bad;
    logic more_cands;
    logic out_busy;
    logic q_nonempty;
  } status_t;

  // Control ROM: one word per step; the jump is taken when the condition holds,
  // otherwise the step counter advances by one.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
    unique case (pc)
      S_IDLE:  w = '{op: OP_IDLE, cond: C_NO_START,       target: S_IDLE};
      S_CHECK: w = '{op: OP_INIT, cond: C_BAD,            target: S_WAIT};
      S_POP:   w = '{op: OP_POP,  cond: C_NEVER,          target: S_IDLE};
      S_SCAN:  w = '{op: OP_PUSH, cond: C_MORE_CANDS,     target: S_SCAN};
      S_WAIT:  w = '{op: OP_NOP,  cond: C_OUT_BUSY,       target: S_WAIT};
      S_EMIT:  w = '{op: OP_EMIT, cond: C_QUEUE_NONEMPTY, target: S_POP};
      S_DONE:  w = '{op: OP_NOP,  cond: C_ALWAYS,         target: S_IDLE};
      default: w = '{op: OP_NOP,  cond: C_ALWAYS,         target: S_IDLE};
    endcase
    return w;
  endfunction

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [NODE_W-1:0] lowest_set(input logic [NODES-1:0] v);
    logic [NODE_W-1:0] idx;
    logic              found;
    idx   = '0;
    found = 1'b0;
    for (int j = 0; j < NODES; j++) begin
      if (v[j] && !found) begin
        idx   = NODE_W'(j);
        found = 1'b1;
      end
    end
    return idx;
  endfunction

endpackage

FILE: rtl/core/bfsam_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bfsam_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/bfsam_seq.sv
`timescale 1ns / 1ps
// Step counter and control ROM sequencer of the breadth-first search block.
module bfsam_seq import bfsam_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           word;
  logic            take;

  always_comb begin
    word = ucode(pc_q);
    unique case (word.cond)
      C_NEVER:          take = 1'b0;
      C_ALWAYS:         take = 1'b1;
      C_NO_START:       take = status_i.no_start;
      C_BAD:            take = status_i.bad;
      C_MORE_CANDS:     take = status_i.more_cands;
      C_OUT_BUSY:       take = status_i.out_busy;
      C_QUEUE_NONEMPTY: take = status_i.q_nonempty;
      default:          take = 1'b0;
    endcase
    pc_d = take ? word.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = word;

endmodule

FILE: rtl/core/bfsam_dp.sv
`timescale 1ns / 1ps
// Datapath: adjacency store, visited map, node queue, neighbor scan and output register.
module bfsam_dp import bfsam_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctrl_i,
  output status_t          status_o,
  input  logic [CNT_W-1:0] cnt_i,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [23:0]      s_tdata_i,
  input  logic             s_tuser_i,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [7:0]       m_tdata_o,
  output logic             m_tlast_o,
  output logic             m_tuser_o
);

  logic [NODES-1:0]  vld_q;
  logic [NODES-1:0]  visited_q;
  logic [NODE_W-1:0] queue_q [NODES];
  logic [CNT_W-1:0]  head_q, tail_q;
  logic [NODE_W-1:0] cur_q, start_q;
  logic              bad_q;
  logic              out_valid_q;
  logic [NODE_W-1:0] out_node_q;
  logic              out_last_q, out_bad_q;

  logic [NODES-1:0]  rd_row, row, mask, cands;
  logic [NODE_W-1:0] pick;
  logic              bad_now, accept, load_en;

  assign accept  = (ctrl_i.op == OP_IDLE) && s_tvalid_i;
  assign load_en = accept && !s_tuser_i;

  bfsam_ram #(
    .WIDTH(NODES),
    .DEPTH(NODES)
  ) u_adj (
    .clk_i    (clk_i),
    .wr_en_i  (load_en),
    .wr_addr_i(s_tdata_i[3:0]),
    .wr_data_i(s_tdata_i[19:4]),
    .rd_en_i  (ctrl_i.op == OP_POP),
    .rd_addr_i(queue_q[head_q[NODE_W-1:0]]),
    .rd_data_o(rd_row)
  );

  always_comb begin
    for (int j = 0; j < NODES; j++) begin
      mask[j] = CNT_W'(j) < cnt_i;
    end
    // A row never loaded since reset reads as all zero.
    row     = vld_q[cur_q] ? rd_row : '0;
    cands   = row & mask & ~visited_q;
    pick    = lowest_set(cands);
    bad_now = {1'b0, start_q} >= cnt_i;
  end

  always_comb begin
    status_o.no_start   = !(s_tvalid_i && s_tuser_i);
    status_o.bad        = bad_now;
    status_o.more_cands = |(cands & (cands - NODES'(1)));
    status_o.out_busy   = out_valid_q && !m_tready_i;
    status_o.q_nonempty = head_q != tail_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      visited_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_en) begin
        vld_q[s_tdata_i[3:0]] <= 1'b1;
      end
      case (ctrl_i.op)
        OP_INIT: begin
          bad_q     <= bad_now;
          head_q    <= '0;
          tail_q    <= bad_now ? CNT_W'(0) : CNT_W'(1);
          visited_q <= bad_now ? '0 : (NODES'(1) << start_q);
        end
        OP_POP: begin
          head_q <= head_q + CNT_W'(1);
        end
        OP_PUSH: begin
          if (|cands) begin
            visited_q[pick] <= 1'b1;
            tail_q          <= tail_q + CNT_W'(1);
          end
        end
        default: ;
      endcase
      if (ctrl_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      start_q <= s_tdata_i[23:20];
    end
    case (ctrl_i.op)
      OP_INIT: queue_q[0] <= start_q;
      OP_POP:  cur_q <= queue_q[head_q[NODE_W-1:0]];
      OP_PUSH: begin
        if (|cands) begin
          queue_q[tail_q[NODE_W-1:0]] <= pick;
        end
      end
      OP_EMIT: begin
        // The last word of a search is known once the queue has drained.
        out_node_q <= bad_q ? '0 : cur_q;
        out_last_q <= bad_q || (head_q == tail_q);
        out_bad_q  <= bad_q;
      end
      default: ;
    endcase
  end

  assign s_tready_o = ctrl_i.op == OP_IDLE;
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'b0, out_node_q};
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_bad_q;

endmodule

FILE: rtl/core/bfs_adjacency_matrix.sv
`timescale 1ns / 1ps
// Load word: taken while idle, with no output word. Search word: accepted while idle, then a
// check step, then per visited node a pop step, scan steps (at least one; the one-push-per-cycle
// neighbor scan), a wait step that holds while the previous output word is not taken and an emit
// step, then a closing step; a bad start goes from check to wait, emit (its word) and closing.
// One search runs at a time; a new word is taken only after the last output is registered.
// Reset (rst_ni low, asynchronous) empties the adjacency store through per-row valid bits,
// clears the visited map and queue pointers, and sets node_count to 16.
module bfs_adjacency_matrix import bfsam_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,    // node_count
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,      // row_index[3:0], row_bits[19:4], search_root[23:20]
  input  logic        s_tuser_i,      // opcode
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o,      // visited_node[3:0], zero fill[7:4]
  output logic        m_tlast_o,
  output logic        m_tuser_o       // bad_start
);

  logic [CNT_W-1:0] node_count_q;
  logic [CNT_W-1:0] cnt_sat;
  ctrl_t            ctrl;
  status_t          status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CNT_W'(NODES);
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  // Counts above the store size saturate to the store size.
  assign cnt_sat = (node_count_q > CNT_W'(NODES)) ? CNT_W'(NODES) : node_count_q;

  bfsam_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .ctrl_o  (ctrl)
  );

  bfsam_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .status_o  (status),
    .cnt_i     (cnt_sat),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tlast_o (m_tlast_o),
    .m_tuser_o (m_tuser_o)
  );

endmodule
